FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the block's checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on a given clock, disabled while the reset is low.
`define SWBB_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("swbb checker: assertion failed");

// Assert a property on clk_i with rst_ni.
`define SWBB_ASSERT(lbl, prop) `SWBB_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

FILE: hdl/swbb_pkg.sv
// ----------------------------------------------------------------------------
// swbb_pkg
// Types, register indexes and constants of the Bollinger band unit.
// ----------------------------------------------------------------------------
package swbb_pkg;

  localparam int unsigned MAX_WINDOW_DEF = 64;
  localparam int unsigned PRICE_BITS_DEF = 24;

  localparam int unsigned MEAN_W  = 24;
  localparam int unsigned STD_W   = 24;
  localparam int unsigned UPPER_W = 25;
  localparam int unsigned LOWER_W = 26;

  localparam int unsigned LEN_REG_W  = 7;
  localparam int unsigned BF_W       = 16;
  localparam int unsigned BF_FRAC    = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_FACTOR   = 2'd1;

  localparam logic [LEN_REG_W-1:0] LEN_RESET = 7'd20;
  localparam logic [BF_W-1:0]      BF_RESET  = 16'd8192;

  localparam int BAND_LIMIT = 1 << UPPER_W;
  localparam logic [UPPER_W-1:0] UPPER_MAX = '1;

  typedef struct packed {
    logic sub;
  } alu_ctl_t;

  typedef struct packed {
    logic carry;
  } alu_stat_t;

endpackage

FILE: hdl/swbb_alu.sv
// ----------------------------------------------------------------------------
// swbb_alu
// Shared add/subtract unit; carry out is set on subtract when a >= b.
// ----------------------------------------------------------------------------
module swbb_alu #(
  parameter int unsigned WIDTH = 32
) (
  input  logic [WIDTH-1:0]  a_i,
  input  logic [WIDTH-1:0]  b_i,
  input  swbb_pkg::alu_ctl_t  ctl_i,
  output logic [WIDTH-1:0]  res_o,
  output swbb_pkg::alu_stat_t stat_o
);

  logic [WIDTH-1:0] b_op;
  logic [WIDTH:0]   sum;

  assign b_op = ctl_i.sub ? ~b_i : b_i;
  assign sum  = {1'b0, a_i} + {1'b0, b_op} + (WIDTH + 1)'(ctl_i.sub);

  assign res_o        = sum[WIDTH-1:0];
  assign stat_o.carry = sum[WIDTH];

endmodule

FILE: hdl/sliding_window_bollinger_bands_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_bollinger_bands_unit
// Sliding-window mean, standard deviation and Bollinger bands of prices.
// ----------------------------------------------------------------------------
// Input channel: close_price_i and start_series_i, taken when in_valid_i is
// high and in_stall_o is low. start_series_i clears the window first.
// Output channel: window_mean_o, std_dev_o, upper_band_o, lower_band_o,
// one item per price once the window holds window_length prices, none before.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i (0 is
// window_length, which also clears the window; 1 is band_factor). Write only
// while no item is in flight.
// Timing: all arithmetic runs on one shared adder, one step per cycle while
// no finished result waits at its last step. The window update subtracts
// the evicted price and its square and adds the new price and its square,
// squaring by shift-add. A result then needs two restoring divisions and a
// square root of PRICE_BITS+log2(MAX_WINDOW)+1 steps each, plus shift-add
// products. in_stall_o is high for the whole computation.
// Reset clears the window and loads window_length 20, band_factor 2.0.
// A finished result waits in the output register while out_stall_i is high;
// a following item is accepted meanwhile and holds at its last step until
// the register frees.
// ----------------------------------------------------------------------------
module sliding_window_bollinger_bands_unit #(
  parameter int unsigned MAX_WINDOW = swbb_pkg::MAX_WINDOW_DEF,
  parameter int unsigned PRICE_BITS = swbb_pkg::PRICE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [swbb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [swbb_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [PRICE_BITS-1:0]                close_price_i,
  input  logic                                 start_series_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [swbb_pkg::MEAN_W-1:0]          window_mean_o,
  output logic [swbb_pkg::STD_W-1:0]           std_dev_o,
  output logic [swbb_pkg::UPPER_W-1:0]         upper_band_o,
  output logic signed [swbb_pkg::LOWER_W-1:0]  lower_band_o
);

  import swbb_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_WINDOW);
  localparam int unsigned LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W = PRICE_BITS + AW;
  localparam int unsigned SQ_W  = 2 * PRICE_BITS + AW;
  localparam int unsigned RW    = SUM_W + 1;
  localparam int unsigned DXW   = 2 * RW;
  localparam int unsigned PW    = (DXW > PRICE_BITS + BF_W) ? DXW : PRICE_BITS + BF_W;
  localparam int unsigned ALUW  = (PW > 28) ? PW : 28;
  localparam int unsigned MPW   = (SUM_W > BF_W) ? SUM_W : BF_W;
  localparam int unsigned CW    = $clog2(RW);
  localparam int unsigned SCW   = PRICE_BITS + BF_W - BF_FRAC;

  localparam logic signed [ALUW-1:0] LO_MAX_X = ALUW'(BAND_LIMIT - 1);
  localparam logic signed [ALUW-1:0] LO_MIN_X = ALUW'(-BAND_LIMIT);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_SUB_OLD  = 5'd1;
  localparam logic [4:0] S_MUL_OLD  = 5'd2;
  localparam logic [4:0] S_SUB_SQ   = 5'd3;
  localparam logic [4:0] S_MUL_NEW  = 5'd4;
  localparam logic [4:0] S_ADD_SQ   = 5'd5;
  localparam logic [4:0] S_ADD_NEW  = 5'd6;
  localparam logic [4:0] S_DIV_MEAN = 5'd7;
  localparam logic [4:0] S_MUL_LSQ  = 5'd8;
  localparam logic [4:0] S_MUL_SUM  = 5'd9;
  localparam logic [4:0] S_DIFF     = 5'd10;
  localparam logic [4:0] S_SQRT     = 5'd11;
  localparam logic [4:0] S_DIV_SD   = 5'd12;
  localparam logic [4:0] S_MUL_BF   = 5'd13;
  localparam logic [4:0] S_UPPER    = 5'd14;
  localparam logic [4:0] S_LOWER    = 5'd15;
  localparam logic [4:0] S_OUT      = 5'd16;

  // control state
  logic [4:0]           state_q, state_d;
  logic [LEN_REG_W-1:0] wl_q, wl_d;
  logic [BF_W-1:0]      bf_q, bf_d;
  logic [AW-1:0]        slot_q, slot_d;
  logic [LEN_W-1:0]     fill_q, fill_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [SQ_W-1:0]      sq_q, sq_d;
  logic                 evict_q, evict_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;

  // datapath
  logic [PRICE_BITS-1:0]    price_q, price_d;
  logic [PRICE_BITS-1:0]    old_q;
  logic [PW-1:0]            acc_q, acc_d;
  logic [PW-1:0]            mc_q, mc_d;
  logic [MPW-1:0]           mp_q, mp_d;
  logic [DXW-1:0]           d_q, d_d;
  logic [RW:0]              rem_q, rem_d;
  logic [RW-1:0]            root_q, root_d;
  logic [RW-1:0]            nq_q, nq_d;
  logic [PRICE_BITS-1:0]    mean_q, mean_d;
  logic [PRICE_BITS-1:0]    sd_q, sd_d;
  logic [SCW-1:0]           scaled_q, scaled_d;
  logic [UPPER_W-1:0]       upper_q, upper_d;
  logic [LOWER_W-1:0]       lower_q, lower_d;
  logic [MEAN_W-1:0]        om_q, om_d;
  logic [STD_W-1:0]         osd_q, osd_d;
  logic [UPPER_W-1:0]       oup_q, oup_d;
  logic [LOWER_W-1:0]       olo_q, olo_d;

  logic [PRICE_BITS-1:0] win_mem [MAX_WINDOW];

  logic [LEN_W-1:0]      len;
  logic                  in_acc;
  logic [AW-1:0]         slot_eff;
  logic [LEN_W-1:0]      slot_inc;
  logic [LEN_W-1:0]      fill_eff;
  logic                  evict;
  logic [PRICE_BITS-1:0] old_v;
  logic                  mul_done;
  logic                  cnt_last;
  logic [LEN_W:0]        div_t;
  logic                  div_ge;
  logic [RW-1:0]         div_q_next;
  logic [LEN_W-1:0]      div_rem_next;
  logic [RW+2:0]         sq_t;
  logic [RW+1:0]         sq_trial;
  logic                  sq_ge;
  logic [RW-1:0]         root_next;

  logic [ALUW-1:0]        alu_a, alu_b, alu_res;
  logic signed [ALUW-1:0] alu_s;
  alu_ctl_t               alu_ctl;
  alu_stat_t              alu_stat;

  swbb_alu #(
    .WIDTH(ALUW)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .ctl_i (alu_ctl),
    .res_o (alu_res),
    .stat_o(alu_stat)
  );

  assign alu_s = $signed(alu_res);

  always_comb begin
    if (wl_q == '0) begin
      len = LEN_W'(1);
    end else if (32'(wl_q) > MAX_WINDOW) begin
      len = LEN_W'(MAX_WINDOW);
    end else begin
      len = LEN_W'(wl_q);
    end
  end

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign slot_eff = (start_series_i || (LEN_W'(slot_q) >= len)) ? '0 : slot_q;
  assign slot_inc = LEN_W'(slot_eff) + LEN_W'(1);
  assign fill_eff = start_series_i ? '0 : fill_q;
  assign evict    = (fill_eff >= len);
  assign old_v    = evict_q ? old_q : '0;

  assign mul_done = (mp_q == '0);
  assign cnt_last = (cnt_q == CW'(RW - 1));

  assign div_t        = {rem_q[LEN_W-1:0], nq_q[RW-1]};
  assign div_ge       = alu_stat.carry;
  assign div_q_next   = {nq_q[RW-2:0], div_ge};
  assign div_rem_next = div_ge ? alu_res[LEN_W-1:0] : div_t[LEN_W-1:0];

  assign sq_t      = {rem_q, d_q[DXW-1 -: 2]};
  assign sq_trial  = {root_q, 2'b01};
  assign sq_ge     = alu_stat.carry;
  assign root_next = {root_q[RW-2:0], sq_ge};

  // shared unit operand select
  always_comb begin
    alu_a       = '0;
    alu_b       = '0;
    alu_ctl.sub = 1'b0;
    unique case (state_q) inside
      S_SUB_OLD: begin
        alu_a       = ALUW'(sum_q);
        alu_b       = ALUW'(old_v);
        alu_ctl.sub = 1'b1;
      end
      S_MUL_OLD, S_MUL_NEW, S_MUL_LSQ, S_MUL_SUM, S_MUL_BF: begin
        alu_a = ALUW'(acc_q);
        alu_b = ALUW'(mc_q);
      end
      S_SUB_SQ: begin
        alu_a       = ALUW'(sq_q);
        alu_b       = ALUW'(acc_q);
        alu_ctl.sub = 1'b1;
      end
      S_ADD_SQ: begin
        alu_a = ALUW'(sq_q);
        alu_b = ALUW'(acc_q);
      end
      S_ADD_NEW: begin
        alu_a = ALUW'(sum_q);
        alu_b = ALUW'(price_q);
      end
      S_DIV_MEAN, S_DIV_SD: begin
        alu_a       = ALUW'(div_t);
        alu_b       = ALUW'(len);
        alu_ctl.sub = 1'b1;
      end
      S_DIFF: begin
        alu_a       = ALUW'(d_q);
        alu_b       = ALUW'(acc_q);
        alu_ctl.sub = 1'b1;
      end
      S_SQRT: begin
        alu_a       = ALUW'(sq_t);
        alu_b       = ALUW'(sq_trial);
        alu_ctl.sub = 1'b1;
      end
      S_UPPER: begin
        alu_a = ALUW'(mean_q);
        alu_b = ALUW'(scaled_q);
      end
      S_LOWER: begin
        alu_a       = ALUW'(mean_q);
        alu_b       = ALUW'(scaled_q);
        alu_ctl.sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    wl_d        = wl_q;
    bf_d        = bf_q;
    slot_d      = slot_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    sq_d        = sq_q;
    evict_d     = evict_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    price_d     = price_q;
    acc_d       = acc_q;
    mc_d        = mc_q;
    mp_d        = mp_q;
    d_d         = d_q;
    rem_d       = rem_q;
    root_d      = root_q;
    nq_d        = nq_q;
    mean_d      = mean_q;
    sd_d        = sd_q;
    scaled_d    = scaled_q;
    upper_d     = upper_q;
    lower_d     = lower_q;
    om_d        = om_q;
    osd_d       = osd_q;
    oup_d       = oup_q;
    olo_d       = olo_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          price_d = close_price_i;
          evict_d = evict;
          fill_d  = evict ? len : fill_eff + LEN_W'(1);
          slot_d  = (slot_inc >= len) ? '0 : AW'(slot_inc);
          if (start_series_i) begin
            sum_d = '0;
            sq_d  = '0;
          end
          state_d = S_SUB_OLD;
        end
      end
      S_SUB_OLD: begin
        sum_d   = alu_res[SUM_W-1:0];
        acc_d   = '0;
        mc_d    = PW'(old_v);
        mp_d    = MPW'(old_v);
        state_d = S_MUL_OLD;
      end
      S_SUB_SQ: begin
        sq_d    = alu_res[SQ_W-1:0];
        acc_d   = '0;
        mc_d    = PW'(price_q);
        mp_d    = MPW'(price_q);
        state_d = S_MUL_NEW;
      end
      S_ADD_SQ: begin
        sq_d    = alu_res[SQ_W-1:0];
        state_d = S_ADD_NEW;
      end
      S_ADD_NEW: begin
        sum_d = alu_res[SUM_W-1:0];
        nq_d  = RW'(alu_res[SUM_W-1:0]);
        rem_d = '0;
        cnt_d = '0;
        state_d = (fill_q >= len) ? S_DIV_MEAN : S_IDLE;
      end
      S_DIV_MEAN: begin
        nq_d  = div_q_next;
        rem_d = (RW + 1)'(div_rem_next);
        cnt_d = cnt_q + CW'(1);
        if (cnt_last) begin
          mean_d  = PRICE_BITS'(div_q_next);
          cnt_d   = '0;
          acc_d   = '0;
          mc_d    = PW'(sq_q);
          mp_d    = MPW'(len);
          state_d = S_MUL_LSQ;
        end
      end
      S_MUL_OLD, S_MUL_NEW, S_MUL_LSQ, S_MUL_SUM, S_MUL_BF: begin
        if (!mul_done) begin
          if (mp_q[0]) begin
            acc_d = alu_res[PW-1:0];
          end
          mc_d = mc_q << 1;
          mp_d = mp_q >> 1;
        end else begin
          case (state_q)
            S_MUL_OLD: state_d = S_SUB_SQ;
            S_MUL_NEW: state_d = S_ADD_SQ;
            S_MUL_LSQ: begin
              d_d     = acc_q[DXW-1:0];
              acc_d   = '0;
              mc_d    = PW'(sum_q);
              mp_d    = MPW'(sum_q);
              state_d = S_MUL_SUM;
            end
            S_MUL_SUM: state_d = S_DIFF;
            default: begin
              scaled_d = acc_q[BF_FRAC +: SCW];
              state_d  = S_UPPER;
            end
          endcase
        end
      end
      S_DIFF: begin
        d_d     = alu_stat.carry ? alu_res[DXW-1:0] : '0;
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = '0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        rem_d  = sq_ge ? alu_res[RW:0] : sq_t[RW:0];
        root_d = root_next;
        d_d    = d_q << 2;
        cnt_d  = cnt_q + CW'(1);
        if (cnt_last) begin
          nq_d    = root_next;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = S_DIV_SD;
        end
      end
      S_DIV_SD: begin
        nq_d  = div_q_next;
        rem_d = (RW + 1)'(div_rem_next);
        cnt_d = cnt_q + CW'(1);
        if (cnt_last) begin
          sd_d    = PRICE_BITS'(div_q_next);
          cnt_d   = '0;
          acc_d   = '0;
          mc_d    = PW'(PRICE_BITS'(div_q_next));
          mp_d    = MPW'(bf_q);
          state_d = S_MUL_BF;
        end
      end
      S_UPPER: begin
        upper_d = (alu_res > ALUW'(UPPER_MAX)) ? UPPER_MAX : alu_res[UPPER_W-1:0];
        state_d = S_LOWER;
      end
      S_LOWER: begin
        if (alu_s < LO_MIN_X) begin
          lower_d = LOWER_W'(LO_MIN_X);
        end else if (alu_s > LO_MAX_X) begin
          lower_d = LOWER_W'(LO_MAX_X);
        end else begin
          lower_d = alu_res[LOWER_W-1:0];
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          om_d        = MEAN_W'(mean_q);
          osd_d       = STD_W'(sd_q);
          oup_d       = upper_q;
          olo_d       = lower_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_LENGTH: begin
          wl_d   = cfg_data_i[LEN_REG_W-1:0];
          fill_d = '0;
          slot_d = '0;
          sum_d  = '0;
          sq_d   = '0;
        end
        REG_BAND_FACTOR: begin
          bf_d = cfg_data_i[BF_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wl_q        <= LEN_RESET;
      bf_q        <= BF_RESET;
      slot_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      evict_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wl_q        <= wl_d;
      bf_q        <= bf_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      sq_q        <= sq_d;
      evict_q     <= evict_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q  <= price_d;
    acc_q    <= acc_d;
    mc_q     <= mc_d;
    mp_q     <= mp_d;
    d_q      <= d_d;
    rem_q    <= rem_d;
    root_q   <= root_d;
    nq_q     <= nq_d;
    mean_q   <= mean_d;
    sd_q     <= sd_d;
    scaled_q <= scaled_d;
    upper_q  <= upper_d;
    lower_q  <= lower_d;
    om_q     <= om_d;
    osd_q    <= osd_d;
    oup_q    <= oup_d;
    olo_q    <= olo_d;
  end

  // read the evicted price and store the new one
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      win_mem[slot_eff] <= close_price_i;
      old_q             <= win_mem[slot_eff];
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign window_mean_o = om_q;
  assign std_dev_o     = osd_q;
  assign upper_band_o  = oup_q;
  assign lower_band_o  = $signed(olo_q);

endmodule

FILE: hdl/swbb_checker.sv
// ----------------------------------------------------------------------------
// swbb_checker
// Port-level checks of the Bollinger band unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swbb_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [swbb_pkg::MEAN_W-1:0]         window_mean_o,
  input logic [swbb_pkg::STD_W-1:0]          std_dev_o,
  input logic [swbb_pkg::UPPER_W-1:0]        upper_band_o,
  input logic signed [swbb_pkg::LOWER_W-1:0] lower_band_o
);

  // hold a stalled result
  `SWBB_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(window_mean_o) && $stable(std_dev_o) && $stable(upper_band_o) && $stable(lower_band_o))

  // busy after taking an item
  `SWBB_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o)

  // results come only out of a running computation
  `SWBB_ASSERT(a_result_from_work, $rose(out_valid_o) |-> $past(in_stall_o))

  // bands stay ordered
  `SWBB_ASSERT(a_band_order, out_valid_o |-> $signed({1'b0, upper_band_o}) >= lower_band_o)

endmodule

bind sliding_window_bollinger_bands_unit swbb_checker u_swbb_checker (.*);
